// ===== hw/rtl/mtep_pkg.sv =====
// mtep_pkg: shared types and constants for the track event parser
// no dependencies
package mtep_pkg;

   localparam int TickBitsDefault = 32;

   typedef enum logic [3:0] {
      KIND_NOTEOFF   = 4'd0,
      KIND_NOTEON    = 4'd1,
      KIND_KEYPRESS  = 4'd2,
      KIND_CTRL      = 4'd3,
      KIND_PROGRAM   = 4'd4,
      KIND_CHANPRESS = 4'd5,
      KIND_BEND      = 4'd6,
      KIND_SYXSTART  = 4'd7,
      KIND_SYXBYTE   = 4'd8,
      KIND_TEMPO     = 4'd9,
      KIND_KEY       = 4'd10,
      KIND_END       = 4'd11,
      KIND_ERROR     = 4'd12
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NO_STATUS = 3'd0,
      ERR_BAD_FX    = 3'd1,
      ERR_LONG_VLQ  = 3'd2,
      ERR_SHORT_META = 3'd3,
      ERR_TRUNCATED = 3'd4
   } err_type;

   typedef enum logic [11:0] {
      PH_DELTA   = 12'b000000000001,
      PH_STATUS  = 12'b000000000010,
      PH_DATA1   = 12'b000000000100,
      PH_DATA2   = 12'b000000001000,
      PH_SYSLEN  = 12'b000000010000,
      PH_SYSBODY = 12'b000000100000,
      PH_MTYPE   = 12'b000001000000,
      PH_MLEN    = 12'b000010000000,
      PH_PORT    = 12'b000100000000,
      PH_TEMPO   = 12'b001000000000,
      PH_KEY     = 12'b010000000000,
      PH_SKIP    = 12'b100000000000
   } phase_type;

   localparam logic [7:0] META_PORT  = 8'h21;
   localparam logic [7:0] META_END   = 8'h2f;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_KEY   = 8'h59;
   localparam logic [7:0] STAT_SYX   = 8'hf0;
   localparam logic [7:0] STAT_ESC   = 8'hf7;
   localparam logic [7:0] STAT_META  = 8'hff;

   // one result item
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] tick;
      logic [7:0]  port;
      logic [3:0]  channel;
      logic [6:0]  first_data;
      logic [6:0]  second_data;
      logic [28:0] value;
      logic [7:0]  key_sharps;
      logic        key_minor;
      logic [2:0]  error_code;
      logic        last;
   } result_type;

   // up to two results caused by one byte
   typedef struct packed {
      logic [1:0]  count;
      result_type  r0;
      result_type  r1;
   } bundle_type;

endpackage

// ===== hw/rtl/mtep_front.sv =====
// mtep_front: accepts track bytes, runs the parse state machine, builds result bundles
// depends on mtep_pkg
module mtep_front
   import mtep_pkg::*;
#(
   parameter int TICK_BITS = TickBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       smpte,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] data_byte,
   input  logic       track_start,
   input  logic       track_last,
   output logic       bnd_valid,
   input  logic       bnd_ready,
   output bundle_type bnd
);

   phase_type            phase_ff, phase_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [27:0]          vlq_ff, vlq_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [7:0]           run_ff, run_in, cur_ff, cur_in, port_ff, port_in;
   logic [6:0]           held_ff, held_in;
   logic [7:0]           mtype_ff, mtype_in, keyb_ff, keyb_in;
   logic [28:0]          left_ff, left_in;
   logic [23:0]          tempo_ff, tempo_in;
   logic                 closed_ff, closed_in;
   logic                 bvalid_ff;
   bundle_type           bnd_ff, bnd_in;

   logic       take;
   logic [1:0] n;
   result_type r0, r1;

   assign in_ready  = !bvalid_ff || bnd_ready;
   assign take      = in_valid && in_ready;
   assign bnd_valid = bvalid_ff;
   assign bnd       = bnd_ff;

   function automatic result_type mk(input logic [3:0] k, input logic [31:0] t,
                                     input logic [7:0] p);
      result_type r;
      r      = '0;
      r.kind = k;
      r.tick = t;
      r.port = p;
      return r;
   endfunction

   always_comb begin
      logic [31:0] t;
      logic [7:0]  p, cs;
      logic [27:0] vn;
      logic [28:0] bl, bdec;
      logic [1:0]  vc;
      logic        emit_chan, chan2, err, closed, one_byte;
      logic [6:0]  sec;
      logic [2:0]  ecode;
      logic [23:0] tacc;
      result_type  ra, rb;

      phase_in = phase_ff; tick_in = tick_ff; vlq_in = vlq_ff; cnt_in = cnt_ff;
      run_in = run_ff; cur_in = cur_ff; port_in = port_ff; held_in = held_ff;
      mtype_in = mtype_ff; keyb_in = keyb_ff; left_in = left_ff; tempo_in = tempo_ff;
      closed_in = closed_ff;
      n = 2'd0; r0 = '0; r1 = '0;
      emit_chan = 1'b0; chan2 = 1'b0; sec = '0; err = 1'b0; ecode = ERR_NO_STATUS;
      one_byte = 1'b0; tacc = '0;
      ra = '0; rb = '0;

      if (track_start) begin
         tick_in = '0; run_in = '0; cur_in = '0; port_in = '0; phase_in = PH_DELTA;
         vlq_in = '0; cnt_in = '0; left_in = '0; closed_in = 1'b0;
      end
      closed = closed_in;
      t  = 32'(tick_in);
      p  = port_in;
      cs = cur_in;
      bl = left_in;
      bdec = (bl != '0) ? bl - 29'd1 : bl;
      vn = {vlq_in[20:0], data_byte[6:0]};
      vc = cnt_in;

      if (!closed) begin
         unique case (phase_in)
            PH_DELTA, PH_SYSLEN, PH_MLEN: begin
               vlq_in = vn;
               if (data_byte[7]) begin
                  if (vc == 2'd3) begin
                     err = 1'b1; ecode = ERR_LONG_VLQ;
                  end else begin
                     cnt_in = vc + 2'd1;
                  end
               end else begin
                  vlq_in = '0; cnt_in = '0;
                  if (phase_in == PH_DELTA) begin
                     tick_in  = tick_in + TICK_BITS'(vn);
                     phase_in = PH_STATUS;
                  end else if (phase_in == PH_SYSLEN) begin
                     if (!track_last) begin
                        ra = mk(KIND_SYXSTART, t, p);
                        ra.value = {1'b0, vn} + {28'd0, (cs == STAT_SYX)};
                        n = 2'd1;
                        if (cs == STAT_SYX) begin
                           rb = mk(KIND_SYXBYTE, t, p);
                           rb.value = 29'(STAT_SYX);
                           n = 2'd2;
                        end
                        left_in  = {1'b0, vn};
                        phase_in = (vn != '0) ? PH_SYSBODY : PH_DELTA;
                     end
                  end else begin
                     left_in = {1'b0, vn};
                     case (mtype_ff)
                        META_PORT: begin
                           if (vn == '0) begin
                              err = 1'b1; ecode = ERR_SHORT_META;
                           end else phase_in = PH_PORT;
                        end
                        META_END: begin
                           ra = mk(KIND_END, t, p); n = 2'd1;
                           closed_in = 1'b1; phase_in = PH_DELTA;
                        end
                        META_TEMPO: begin
                           if (vn < 28'd3) begin
                              err = 1'b1; ecode = ERR_SHORT_META;
                           end else if (smpte) phase_in = PH_SKIP;
                           else begin
                              tempo_in = '0; cnt_in = '0; phase_in = PH_TEMPO;
                           end
                        end
                        META_KEY: begin
                           if (vn < 28'd2) begin
                              err = 1'b1; ecode = ERR_SHORT_META;
                           end else begin
                              cnt_in = '0; phase_in = PH_KEY;
                           end
                        end
                        default: phase_in = (vn != '0) ? PH_SKIP : PH_DELTA;
                     endcase
                  end
               end
            end
            PH_STATUS: begin
               if (data_byte[7]) begin
                  if (data_byte < STAT_SYX) begin
                     run_in = data_byte; cur_in = data_byte; phase_in = PH_DATA1;
                  end else if (data_byte == STAT_SYX || data_byte == STAT_ESC) begin
                     cur_in = data_byte; phase_in = PH_SYSLEN;
                  end else if (data_byte == STAT_META) begin
                     cur_in = data_byte; phase_in = PH_MTYPE;
                  end else begin
                     err = 1'b1; ecode = ERR_BAD_FX;
                  end
               end else if (run_in == '0) begin
                  err = 1'b1; ecode = ERR_NO_STATUS;
               end else begin
                  cur_in = run_in; cs = run_in;
                  held_in = data_byte[6:0];
                  one_byte = (cs[7:4] == 4'hc) || (cs[7:4] == 4'hd);
                  if (one_byte) emit_chan = 1'b1;
                  else phase_in = PH_DATA2;
               end
            end
            PH_DATA1: begin
               held_in = data_byte[6:0];
               one_byte = (cs[7:4] == 4'hc) || (cs[7:4] == 4'hd);
               if (one_byte) emit_chan = 1'b1;
               else phase_in = PH_DATA2;
            end
            PH_DATA2: begin
               emit_chan = 1'b1; chan2 = 1'b1; sec = data_byte[6:0];
            end
            PH_SYSBODY: begin
               ra = mk(KIND_SYXBYTE, t, p); ra.value = {21'd0, data_byte};
               n = 2'd1;
               left_in = bdec;
               if (bdec == '0) phase_in = PH_DELTA;
            end
            PH_MTYPE: begin
               mtype_in = data_byte; vlq_in = '0; cnt_in = '0; phase_in = PH_MLEN;
            end
            PH_PORT: begin
               port_in = data_byte; left_in = bdec;
               phase_in = (bdec != '0) ? PH_SKIP : PH_DELTA;
            end
            PH_TEMPO: begin
               tacc = {tempo_ff[15:0], data_byte};
               tempo_in = tacc; left_in = bdec;
               if (vc == 2'd2) begin
                  cnt_in = '0;
                  ra = mk(KIND_TEMPO, t, p); ra.value = {5'd0, tacc}; n = 2'd1;
                  phase_in = (bdec != '0) ? PH_SKIP : PH_DELTA;
               end else cnt_in = vc + 2'd1;
            end
            PH_KEY: begin
               left_in = bdec;
               if (vc == 2'd0) begin
                  keyb_in = data_byte; cnt_in = 2'd1;
               end else begin
                  cnt_in = '0;
                  ra = mk(KIND_KEY, t, p);
                  ra.key_sharps = keyb_ff; ra.key_minor = (data_byte != 8'd0);
                  n = 2'd1;
                  phase_in = (bdec != '0) ? PH_SKIP : PH_DELTA;
               end
            end
            PH_SKIP: begin
               left_in = bdec;
               if (bdec == '0) phase_in = PH_DELTA;
            end
            default: phase_in = PH_DELTA;
         endcase

         if (emit_chan) begin
            ra = mk(4'(cs[7:4] - 4'd8), t, p);
            ra.channel = cs[3:0]; ra.first_data = held_in;
            ra.second_data = chan2 ? sec : 7'd0;
            n = 2'd1; phase_in = PH_DELTA;
         end
         if (err) begin
            ra = mk(KIND_ERROR, t, p); ra.error_code = ecode;
            n = 2'd1; closed_in = 1'b1; phase_in = PH_DELTA;
         end
         // truncated track: error follows whatever this byte gave
         if (track_last && !closed_in) begin
            closed_in = 1'b1; phase_in = PH_DELTA;
            if (n == 2'd0) begin
               ra = mk(KIND_ERROR, 32'(tick_in), port_in);
               ra.error_code = ERR_TRUNCATED; n = 2'd1;
            end else begin
               rb = mk(KIND_ERROR, 32'(tick_in), port_in);
               rb.error_code = ERR_TRUNCATED; n = 2'd2;
            end
         end
      end
      if (n == 2'd1) ra.last = 1'b1;
      if (n == 2'd2) rb.last = 1'b1;
      r0 = ra; r1 = rb;
      bnd_in.count = n; bnd_in.r0 = r0; bnd_in.r1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA; tick_ff <= '0; vlq_ff <= '0; cnt_ff <= '0;
         run_ff <= '0; cur_ff <= '0; port_ff <= '0; held_ff <= '0;
         mtype_ff <= '0; keyb_ff <= '0; left_ff <= '0; tempo_ff <= '0;
         closed_ff <= 1'b0; bvalid_ff <= 1'b0;
      end else begin
         if (bvalid_ff && bnd_ready) bvalid_ff <= 1'b0;
         if (take) begin
            phase_ff <= phase_in; tick_ff <= tick_in; vlq_ff <= vlq_in; cnt_ff <= cnt_in;
            run_ff <= run_in; cur_ff <= cur_in; port_ff <= port_in; held_ff <= held_in;
            mtype_ff <= mtype_in; keyb_ff <= keyb_in; left_ff <= left_in;
            tempo_ff <= tempo_in; closed_ff <= closed_in;
            if (n != 2'd0) bvalid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && n != 2'd0) bnd_ff <= bnd_in;
   end

endmodule

// ===== hw/rtl/mtep_queue.sv =====
// mtep_queue: two-entry queue of result items between parser and output
// depends on mtep_pkg
module mtep_queue
   import mtep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       bnd_valid,
   output logic       bnd_ready,
   input  bundle_type bnd,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   result_type  slot_ff [2];
   logic [1:0]  fill_ff;
   logic        rd_ff, rd_in;
   logic        pop, push;
   logic        wr_sel;

   assign pop       = out_valid && out_ready;
   assign out_valid = fill_ff != 2'd0;
   assign out_item  = slot_ff[rd_ff];
   // take a whole bundle only when it fits
   assign bnd_ready = (fill_ff == 2'd0)
                   || (fill_ff == 2'd1 && (pop || bnd.count == 2'd1))
                   || (fill_ff == 2'd2 && pop && bnd.count == 2'd1);
   assign push      = bnd_valid && bnd_ready;
   assign rd_in     = pop ? !rd_ff : rd_ff;
   // first free slot behind whatever stays queued
   assign wr_sel    = rd_in ^ ((fill_ff == 2'd1 && !pop) || (fill_ff == 2'd2 && pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rd_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_ff - {1'b0, pop} + (push ? bnd.count : 2'd0);
         rd_ff   <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_sel] <= bnd.r0;
         if (bnd.count == 2'd2) slot_ff[!wr_sel] <= bnd.r1;
      end
   end

endmodule

// ===== hw/rtl/midi_track_event_parser.sv =====
// midi_track_event_parser: top level of the track event byte parser
// depends on mtep_pkg, mtep_front, mtep_queue
//
// Takes one track chunk byte per cycle and gives channel, sysex, tempo, key,
// end-of-track and error items with the absolute tick. A byte is taken every
// cycle while the output keeps up; a byte that causes two items can hold the
// input, as the single output port drains the two-entry result queue. A byte's
// first item is registered in the front bundle register, then in a queue slot.
module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int TICK_BITS = TickBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_track_start,
   input  logic        req_track_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [31:0] rsp_tick,
   output logic [7:0]  rsp_port,
   output logic [3:0]  rsp_channel,
   output logic [6:0]  rsp_first_data,
   output logic [6:0]  rsp_second_data,
   output logic [28:0] rsp_value,
   output logic signed [7:0] rsp_key_sharps,
   output logic        rsp_key_minor,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   logic       smpte_ff;
   logic       bnd_valid, bnd_ready;
   bundle_type bnd;
   result_type item;

   always_ff @(posedge clock) begin
      if (reset) smpte_ff <= 1'b0;
      else if (csr_write_enable) smpte_ff <= csr_write_data;
   end

   mtep_front #(.TICK_BITS(TICK_BITS)) u_front (
      .clock, .reset, .smpte(smpte_ff),
      .in_valid(req_valid), .in_ready(req_ready),
      .data_byte(req_data_byte), .track_start(req_track_start),
      .track_last(req_track_last),
      .bnd_valid, .bnd_ready, .bnd
   );

   mtep_queue u_queue (
      .clock, .reset, .bnd_valid, .bnd_ready, .bnd,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_item(item)
   );

   assign rsp_kind        = item.kind;
   assign rsp_tick        = item.tick;
   assign rsp_port        = item.port;
   assign rsp_channel     = item.channel;
   assign rsp_first_data  = item.first_data;
   assign rsp_second_data = item.second_data;
   assign rsp_value       = item.value;
   assign rsp_key_sharps  = item.key_sharps;
   assign rsp_key_minor   = item.key_minor;
   assign rsp_error_code  = item.error_code;
   assign rsp_last        = item.last;

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for midi_track_event_parser
// depends on mtep_pkg and the parser rtl; carries its own model of the parser
`timescale 1ns / 100ps

module tb;
   import mtep_pkg::*;

   localparam int WatchLimit = 3000;

   typedef struct {
      logic [7:0] b;
      bit         s;
      bit         l;
   } tb_byte_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_track_start;
   logic        req_track_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_kind;
   logic [31:0] rsp_tick;
   logic [7:0]  rsp_port;
   logic [3:0]  rsp_channel;
   logic [6:0]  rsp_first_data;
   logic [6:0]  rsp_second_data;
   logic [28:0] rsp_value;
   logic signed [7:0] rsp_key_sharps;
   logic        rsp_key_minor;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;

   midi_track_event_parser u_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_byte(req_data_byte),
      .req_track_start(req_track_start), .req_track_last(req_track_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_tick(rsp_tick), .rsp_port(rsp_port), .rsp_channel(rsp_channel),
      .rsp_first_data(rsp_first_data), .rsp_second_data(rsp_second_data),
      .rsp_value(rsp_value), .rsp_key_sharps(rsp_key_sharps),
      .rsp_key_minor(rsp_key_minor), .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last)
   );

   // parser model state
   bit          smpte;
   phase_type   phase;
   logic [31:0] tick_total;
   logic [27:0] vlq_acc;
   int          vlq_cnt;
   logic [7:0]  running_st;
   logic [7:0]  cur_st;
   logic [7:0]  port_num;
   logic [6:0]  held;
   logic [7:0]  meta_kind;
   logic [28:0] left;
   logic [23:0] tempo_acc;
   logic [7:0]  key_b;
   bit          closed;

   result_type  pending[$];
   result_type  expected_events[$];
   tb_byte_type track_bytes[$];

   int  n_err;
   bit  tx_idle_on;
   bit  rx_idle_on;
   int  rx_hold;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- model ----------------
   function automatic result_type blank(kind_type k);
      result_type r;
      r = '0;
      r.kind = k;
      r.tick = tick_total;
      r.port = port_num;
      return r;
   endfunction

   function automatic void raise_err(err_type e);
      result_type r;
      r = blank(KIND_ERROR);
      r.error_code = e;
      pending.insert(pending.size(), r);
      closed = 1;
      phase = PH_DELTA;
   endfunction

   function automatic void chan_event(logic [6:0] second);
      result_type r;
      r = blank(kind_type'(cur_st[7:4] - 4'd8));
      r.channel = cur_st[3:0];
      r.first_data = held;
      r.second_data = second;
      pending.insert(pending.size(), r);
      phase = PH_DELTA;
   endfunction

   function automatic void take_first(logic [7:0] b);
      held = b[6:0];
      if (cur_st[7:4] == 4'hc || cur_st[7:4] == 4'hd) chan_event('0);
      else phase = PH_DATA2;
   endfunction

   function automatic void body_done();
      phase = (left != 0) ? PH_SKIP : PH_DELTA;
   endfunction

   function automatic void meta_begin(logic [27:0] len);
      left = 29'(len);
      case (meta_kind)
         META_PORT: begin
            if (len < 1) raise_err(ERR_SHORT_META);
            else phase = PH_PORT;
         end
         META_END: begin
            pending.insert(pending.size(), blank(KIND_END));
            closed = 1;
            phase = PH_DELTA;
         end
         META_TEMPO: begin
            if (len < 3) raise_err(ERR_SHORT_META);
            else if (smpte) phase = PH_SKIP;
            else begin
               tempo_acc = 0;
               vlq_cnt = 0;
               phase = PH_TEMPO;
            end
         end
         META_KEY: begin
            if (len < 2) raise_err(ERR_SHORT_META);
            else begin
               vlq_cnt = 0;
               phase = PH_KEY;
            end
         end
         default: phase = (len != 0) ? PH_SKIP : PH_DELTA;
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] b, bit start, bit lastb);
      result_type  r;
      logic [27:0] len;
      bit          f0;
      pending.delete();
      if (start) begin
         tick_total = 0;
         running_st = 0;
         cur_st = 0;
         port_num = 0;
         phase = PH_DELTA;
         vlq_acc = 0;
         vlq_cnt = 0;
         left = 0;
         closed = 0;
      end
      if (closed) return;
      case (phase)
         PH_DELTA, PH_SYSLEN, PH_MLEN: begin
            vlq_acc = {vlq_acc[20:0], b[6:0]};
            if (b[7]) begin
               if (vlq_cnt >= 3) raise_err(ERR_LONG_VLQ);
               else vlq_cnt++;
            end else begin
               len = vlq_acc;
               vlq_acc = 0;
               vlq_cnt = 0;
               if (phase == PH_DELTA) begin
                  tick_total = tick_total + 32'(len);
                  phase = PH_STATUS;
               end else if (phase == PH_SYSLEN) begin
                  f0 = (cur_st == STAT_SYX);
                  if (!lastb) begin
                     r = blank(KIND_SYXSTART);
                     r.value = 29'(len) + 29'(f0);
                     pending.insert(pending.size(), r);
                     if (f0) begin
                        r = blank(KIND_SYXBYTE);
                        r.value = 29'(STAT_SYX);
                        pending.insert(pending.size(), r);
                     end
                     left = 29'(len);
                     phase = (len != 0) ? PH_SYSBODY : PH_DELTA;
                  end
               end else meta_begin(len);
            end
         end
         PH_STATUS: begin
            if (b[7]) begin
               if (b < STAT_SYX) begin
                  running_st = b;
                  cur_st = b;
                  phase = PH_DATA1;
               end else if (b == STAT_SYX || b == STAT_ESC) begin
                  cur_st = b;
                  phase = PH_SYSLEN;
               end else if (b == STAT_META) begin
                  cur_st = b;
                  phase = PH_MTYPE;
               end else raise_err(ERR_BAD_FX);
            end else if (running_st == 0) raise_err(ERR_NO_STATUS);
            else begin
               cur_st = running_st;
               take_first(b);
            end
         end
         PH_DATA1: take_first(b);
         PH_DATA2: chan_event(b[6:0]);
         PH_SYSBODY: begin
            r = blank(KIND_SYXBYTE);
            r.value = 29'(b);
            pending.insert(pending.size(), r);
            if (left != 0) left--;
            if (left == 0) phase = PH_DELTA;
         end
         PH_MTYPE: begin
            meta_kind = b;
            vlq_acc = 0;
            vlq_cnt = 0;
            phase = PH_MLEN;
         end
         PH_PORT: begin
            port_num = b;
            if (left != 0) left--;
            body_done();
         end
         PH_TEMPO: begin
            tempo_acc = {tempo_acc[15:0], b};
            if (left != 0) left--;
            vlq_cnt++;
            if (vlq_cnt >= 3) begin
               vlq_cnt = 0;
               r = blank(KIND_TEMPO);
               r.value = 29'(tempo_acc);
               pending.insert(pending.size(), r);
               body_done();
            end
         end
         PH_KEY: begin
            if (left != 0) left--;
            if (vlq_cnt == 0) begin
               key_b = b;
               vlq_cnt = 1;
            end else begin
               vlq_cnt = 0;
               r = blank(KIND_KEY);
               r.key_sharps = key_b;
               r.key_minor = (b != 0);
               pending.insert(pending.size(), r);
               body_done();
            end
         end
         default: begin
            if (left != 0) left--;
            if (left == 0) phase = PH_DELTA;
         end
      endcase
      if (lastb && !closed) raise_err(ERR_TRUNCATED);
      if (pending.size() > 0) pending[pending.size() - 1].last = 1'b1;
      foreach (pending[i]) expected_events.insert(expected_events.size(), pending[i]);
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
      n_err++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected item kind", 32'(rsp_kind), 32'd0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_tick !== want.tick) report_mismatch("tick", rsp_tick, want.tick);
            if (rsp_port !== want.port)
               report_mismatch("port", 32'(rsp_port), 32'(want.port));
            if (rsp_channel !== want.channel)
               report_mismatch("channel", 32'(rsp_channel), 32'(want.channel));
            if (rsp_first_data !== want.first_data)
               report_mismatch("first_data", 32'(rsp_first_data), 32'(want.first_data));
            if (rsp_second_data !== want.second_data)
               report_mismatch("second_data", 32'(rsp_second_data), 32'(want.second_data));
            if (rsp_value !== want.value)
               report_mismatch("value", 32'(rsp_value), 32'(want.value));
            if (rsp_key_sharps !== want.key_sharps)
               report_mismatch("key_sharps", 32'(rsp_key_sharps), 32'(want.key_sharps));
            if (rsp_key_minor !== want.key_minor)
               report_mismatch("key_minor", 32'(rsp_key_minor), 32'(want.key_minor));
            if (rsp_error_code !== want.error_code)
               report_mismatch("error_code", 32'(rsp_error_code), 32'(want.error_code));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // result side: random stall bursts, plus a long hold when asked
   initial begin
      int gap;
      rsp_ready = 1'b0;
      gap = 0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 19);
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_byte(logic [7:0] b, bit s, bit l);
      int g;
      if (tx_idle_on && $urandom_range(0, 9) == 0) begin
         g = $urandom_range(1, 19);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end else @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_track_start <= s;
      req_track_last <= l;
      do @(posedge clock); while (!req_ready);
      parse_byte(b, s, l);
   endtask

   task automatic play_track();
      while (track_bytes.size() > 0) begin
         tb_byte_type it;
         it = track_bytes.pop_front();
         send_byte(it.b, it.s, it.l);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_events.size() > 0) @(posedge clock);
      // a trailing byte may cause nothing yet still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic set_timing(bit v);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      smpte = v;
   endtask

   function automatic void put(logic [7:0] b);
      tb_byte_type it;
      it.b = b;
      it.s = (track_bytes.size() == 0);
      it.l = 0;
      track_bytes.insert(track_bytes.size(), it);
   endfunction

   function automatic void put_vlq(logic [27:0] v, int n);
      for (int i = n - 1; i > 0; i--) put(8'h80 | 8'((v >> (7 * i)) & 28'h7f));
      put(8'(v & 28'h7f));
   endfunction

   function automatic void put_delta();
      int n;
      n = $urandom_range(0, 19) == 0 ? 4 : $urandom_range(1, 3);
      put_vlq(28'($urandom), n);
   endfunction

   function automatic void build_track();
      int   events;
      int   sel;
      int   len;
      bit   have_rs;
      logic [7:0] mt;
      logic [7:0] rs;
      track_bytes.delete();
      have_rs = 0;
      rs = '0;
      if ($urandom_range(0, 19) == 0) begin
         // noise: raw bytes with random framing
         repeat ($urandom_range(1, 30)) begin
            put(8'($urandom));
            track_bytes[track_bytes.size() - 1].s = ($urandom_range(0, 7) == 0);
         end
         track_bytes[track_bytes.size() - 1].l = ($urandom_range(0, 1) == 1);
         return;
      end
      events = $urandom_range(2, 12);
      repeat (events) begin
         sel = $urandom_range(0, 99);
         if (sel < 2) begin
            // over-long delta time
            repeat (4) put(8'h80 | 8'($urandom_range(0, 127)));
            put(8'($urandom));
         end else begin
            put_delta();
            if (sel < 55) begin
               if (have_rs && $urandom_range(0, 2) == 0) put(8'($urandom_range(0, 127)));
               else begin
                  rs = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
                  put(rs);
                  put(8'($urandom));
                  have_rs = 1;
               end
               if (!(rs[7:4] inside {4'hc, 4'hd})) put(8'($urandom));
            end else if (sel < 67) begin
               put($urandom_range(0, 1) ? STAT_SYX : STAT_ESC);
               len = $urandom_range(0, 6);
               put_vlq(28'(len), $urandom_range(0, 7) == 0 ? 2 : 1);
               repeat (len) put(8'($urandom));
            end else if (sel < 93) begin
               put(STAT_META);
               case ($urandom_range(0, 4))
                  0: mt = META_PORT;
                  1: mt = META_TEMPO;
                  2: mt = META_KEY;
                  3: mt = META_END;
                  default: mt = 8'($urandom);
               endcase
               put(mt);
               len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 6);
               put_vlq(28'(len), 1);
               if (mt == META_END) break;
               repeat (len) put(8'($urandom));
            end else if (sel < 97) put(8'hf0 | 8'($urandom_range(1, 14)));
            else if (!have_rs) put(8'($urandom_range(0, 127)));
         end
      end
      if (track_bytes.size() > 0 && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 3))
            if (track_bytes.size() > 1) void'(track_bytes.pop_back());
      end else if ($urandom_range(0, 6) != 0) begin
         put(8'h00);
         put(STAT_META);
         put(META_END);
         put(8'h00);
      end
      track_bytes[track_bytes.size() - 1].l = 1;
   endfunction

   task automatic test_directed();
      logic [7:0] seq[$];
      seq = '{8'h00, 8'h90, 8'h3c, 8'h7f, 8'h81, 8'h80, 8'hcf, 8'hff,
              8'h00, 8'h45, 8'h00, 8'hf0, 8'h02, 8'h11, 8'hf7,
              8'h00, 8'hff, 8'h51, 8'h03, 8'h07, 8'ha1, 8'h20,
              8'h00, 8'hff, 8'h59, 8'h02, 8'h80, 8'h01, 8'h00, 8'hff, 8'h2f, 8'h00};
      track_bytes.delete();
      foreach (seq[i]) put(seq[i]);
      track_bytes[track_bytes.size() - 1].l = 1;
      play_track();
      // sysex length on the final byte, bad status, data with no status
      track_bytes.delete();
      put(8'h7f); put(STAT_SYX); put(8'h05);
      track_bytes[2].l = 1;
      play_track();
      track_bytes.delete();
      put(8'h00); put(8'hf5);
      play_track();
      track_bytes.delete();
      put(8'h00); put(8'h40); put(8'hee);
      track_bytes[2].l = 1;
      play_track();
   endtask

   task automatic test_random(int n_bytes);
      int sent;
      sent = 0;
      while (sent < n_bytes) begin
         build_track();
         sent += track_bytes.size();
         play_track();
      end
   endtask

   task automatic test_backpressure();
      rx_hold = 400;
      test_random(120);
   endtask

   task automatic test_drain_pause();
      test_random(40);
      wait_drained();
      test_random(40);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_track_start = 1'b0;
      req_track_last = 1'b0;
      rx_hold = 0;
      n_err = 0;
      tx_idle_on = 1;
      rx_idle_on = 1;
      smpte = 0;
      phase = PH_DELTA;
      tick_total = 0; vlq_acc = 0; vlq_cnt = 0; running_st = 0; cur_st = 0;
      port_num = 0; held = 0; meta_kind = 0; left = 0; tempo_acc = 0;
      key_b = 0; closed = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_timing(1'b0);
      test_directed();
      set_timing(1'b1);
      test_random(400);
      set_timing(1'b0);
      test_random(500);
      test_backpressure();
      test_drain_pause();
      set_timing(1'b1);
      test_random(200);
      set_timing(1'b0);
      tx_idle_on = 0;
      rx_idle_on = 0;
      test_random(250);

      while (expected_events.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (n_err == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
